>>> hdl/pid_line_follower_defines.svh
// ----------------------------------------------------------------------------
// pid_line_follower_defines - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PID_LINE_FOLLOWER_DEFINES_SVH
`define PID_LINE_FOLLOWER_DEFINES_SVH

// same-cycle implication
`define PIDLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PIDLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pidlf_pkg.sv
// ----------------------------------------------------------------------------
// pidlf_pkg - shared types and constants
// Register indexes, field widths and limits of the PID line follower.
// ----------------------------------------------------------------------------
package pidlf_pkg;

  localparam int ACCUM_BITS_DEF = 24;
  localparam int SENSOR_W       = 11;
  localparam int PROX_W         = 3;
  localparam int ACCEL_W        = 16;
  localparam int GAIN_W         = 16;
  localparam int DRIVE_W        = 10;
  localparam int ERR_W          = 13;
  localparam int DERIV_W        = 14;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int IN_DATA_W      = 80;
  localparam int OUT_DATA_W     = 24;

  localparam logic [PROX_W:0] FINISH_PROX = 4'd12;
  localparam int              DRIVE_LIMIT = 400;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 10'sd400;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -10'sd400;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GAIN_P        = 3'd0,
    CFG_GAIN_I        = 3'd1,
    CFG_GAIN_D        = 3'd2,
    CFG_BASE_SPEED    = 3'd3,
    CFG_DIRECTION_SEL = 3'd4,
    CFG_DARK_LINE     = 3'd5
  } cfg_reg_t;

  // per-item flags riding along the pipeline
  typedef struct packed {
    logic kill;    // run already over: all-zero result
    logic upside;  // accel z negative
    logic done;    // proximity sum hit the finish count, not upside down
  } stage_flags_t;

endpackage

>>> hdl/pid_line_follower.sv
// ----------------------------------------------------------------------------
// pid_line_follower - PID line follower controller
// Sensor error, integral and derivative feed three Q8.8 gain terms that steer
// the left and right drive around the base speed.
// ----------------------------------------------------------------------------
// Stages: input register, stage 1 register, gain product registers, output
//   register. Throughput: one item per cycle unless out_tready holds it back.
// Integral and last error live in stage 0, so each sample sees the last one's.
// Reset (rst_n low, synchronous): pipeline empty, integral, last error, run
//   flag and all configuration registers cleared to zero.
module pid_line_follower #(
  parameter int ACCUM_BITS = pidlf_pkg::ACCUM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write port
  input  logic                                cfg_wr_en,
  input  logic [pidlf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pidlf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // sample stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // start_req[0], sensor_0[11:1], sensor_1[22:12], sensor_2[33:23],
  // sensor_3[44:34], sensor_4[55:45], prox_left[58:56], prox_right[61:59],
  // accel_z[77:62], zero pad[79:78]
  input  logic [pidlf_pkg::IN_DATA_W-1:0]     in_tdata,
  // drive stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // left_drive[9:0], right_drive[19:10], finished[20], halted[21], zero[23:22]
  output logic [pidlf_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int SW  = pidlf_pkg::SENSOR_W;
  localparam int EW  = pidlf_pkg::ERR_W;
  localparam int DW  = pidlf_pkg::DERIV_W;
  localparam int GW  = pidlf_pkg::GAIN_W;
  localparam int VW  = pidlf_pkg::DRIVE_W;
  localparam int PW  = pidlf_pkg::PROX_W;
  localparam int AW  = ACCUM_BITS;
  localparam int CW  = ACCUM_BITS + 10;   // correction sum
  localparam int LW  = CW + 1;            // base +/- correction
  localparam int QPW = EW + GW - 8;
  localparam int QIW = AW + GW - 8;
  localparam int QDW = DW + GW - 8;

  localparam logic signed [AW-1:0] SUM_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] SUM_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic signed [LW-1:0] LIM_HI  = LW'(pidlf_pkg::DRIVE_LIMIT);
  localparam logic signed [LW-1:0] LIM_LO  = -LIM_HI;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [GW-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic signed [VW-1:0] base_speed_r;
  logic                 direction_sel_r, dark_line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r        <= '0;
      gain_i_r        <= '0;
      gain_d_r        <= '0;
      base_speed_r    <= '0;
      direction_sel_r <= 1'b0;
      dark_line_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (pidlf_pkg::cfg_reg_t'(cfg_addr))
        pidlf_pkg::CFG_GAIN_P:        gain_p_r        <= cfg_wdata[GW-1:0];
        pidlf_pkg::CFG_GAIN_I:        gain_i_r        <= cfg_wdata[GW-1:0];
        pidlf_pkg::CFG_GAIN_D:        gain_d_r        <= cfg_wdata[GW-1:0];
        pidlf_pkg::CFG_BASE_SPEED:    base_speed_r    <= cfg_wdata[VW-1:0];
        pidlf_pkg::CFG_DIRECTION_SEL: direction_sel_r <= cfg_wdata[0];
        pidlf_pkg::CFG_DARK_LINE:     dark_line_r     <= cfg_wdata[0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: each stage moves when the one after it can take it,
  // so a bubble anywhere keeps the input open while the output is stalled
  // --------------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, out_valid_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3      = !out_valid_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = !v0_r || rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) v0_r        <= in_tvalid;
      if (rdy1)      v1_r        <= v0_r;
      if (rdy2)      v2_r        <= v1_r;
      if (rdy3)      out_valid_r <= v2_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: input register
  // --------------------------------------------------------------------------
  logic                          start0_r;
  logic [SW-1:0]                 sens0_r [5];
  logic [PW-1:0]                 prox_l0_r, prox_r0_r;
  logic signed [pidlf_pkg::ACCEL_W-1:0] accel0_r;

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      start0_r   <= in_tdata[0];
      sens0_r[0] <= in_tdata[11:1];
      sens0_r[1] <= in_tdata[22:12];
      sens0_r[2] <= in_tdata[33:23];
      sens0_r[3] <= in_tdata[44:34];
      sens0_r[4] <= in_tdata[55:45];
      prox_l0_r  <= in_tdata[58:56];
      prox_r0_r  <= in_tdata[61:59];
      accel0_r   <= in_tdata[77:62];
    end
  end

  // --------------------------------------------------------------------------
  // stage 0 logic: error, integral and derivative; loop state updates here
  // --------------------------------------------------------------------------
  logic signed [AW-1:0] error_sum_r, error_sum_nxt;
  logic signed [EW-1:0] prev_error_r;
  logic                 run_over_r;

  logic [EW-1:0]        sx [5];
  logic signed [EW-1:0] err;
  logic signed [AW-1:0] sum_base;
  logic signed [EW-1:0] prev_base;
  logic signed [AW:0]   sum_wide;
  logic signed [DW-1:0] deriv;
  logic [PW:0]          prox_sum;
  logic                 fire0;
  pidlf_pkg::stage_flags_t flags0;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      sx[k] = {{(EW-SW){1'b0}}, sens0_r[k]};
    end
    // true error always fits 13 bits, so wrapping arithmetic is exact
    if (dark_line_r) begin
      if (direction_sel_r) err = sx[0] + sx[1] - sx[2] - sx[3];
      else                 err = sx[1] + sx[2] - sx[3] - sx[4];
    end else begin
      err = sx[3] - sx[1];
    end
  end

  // start request clears the loop state ahead of this sample
  assign sum_base  = start0_r ? '0 : error_sum_r;
  assign prev_base = start0_r ? '0 : prev_error_r;
  assign sum_wide  = {sum_base[AW-1], sum_base} + {{(AW+1-EW){err[EW-1]}}, err};
  assign deriv     = {err[EW-1], err} - {prev_base[EW-1], prev_base};
  assign prox_sum  = {1'b0, prox_l0_r} + {1'b0, prox_r0_r};

  always_comb begin
    if (sum_wide[AW] != sum_wide[AW-1]) begin
      error_sum_nxt = sum_wide[AW] ? SUM_MIN : SUM_MAX;
    end else begin
      error_sum_nxt = sum_wide[AW-1:0];
    end
  end

  assign flags0.kill   = run_over_r && !start0_r;
  assign flags0.upside = accel0_r[pidlf_pkg::ACCEL_W-1];
  assign flags0.done   = (prox_sum == pidlf_pkg::FINISH_PROX) && !flags0.upside;
  assign fire0         = v0_r && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      prev_error_r <= '0;
      run_over_r   <= 1'b0;
    end else if (fire0 && !flags0.kill) begin
      error_sum_r  <= error_sum_nxt;
      prev_error_r <= err;
      run_over_r   <= flags0.upside || flags0.done;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1 register
  // --------------------------------------------------------------------------
  logic signed [EW-1:0]    err1_r;
  logic signed [AW-1:0]    sum1_r;
  logic signed [DW-1:0]    deriv1_r;
  pidlf_pkg::stage_flags_t flags1_r, flags2_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      err1_r   <= err;
      sum1_r   <= error_sum_nxt;
      deriv1_r <= deriv;
      flags1_r <= flags0;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: gain multipliers (product registers inside the terms)
  // --------------------------------------------------------------------------
  logic signed [QPW-1:0] qp;
  logic signed [QIW-1:0] qi;
  logic signed [QDW-1:0] qd;

  pidlf_term #(.A_W(EW)) u_term_p (
    .clk (clk), .en (rdy2), .a (err1_r), .gain (gain_p_r), .q (qp)
  );

  pidlf_term #(.A_W(AW)) u_term_i (
    .clk (clk), .en (rdy2), .a (sum1_r), .gain (gain_i_r), .q (qi)
  );

  pidlf_term #(.A_W(DW)) u_term_d (
    .clk (clk), .en (rdy2), .a (deriv1_r), .gain (gain_d_r), .q (qd)
  );

  always_ff @(posedge clk) begin
    if (rdy2) flags2_r <= flags1_r;
  end

  // --------------------------------------------------------------------------
  // stage 2 logic: correction, wheel speeds, saturation
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] corr;
  logic signed [LW-1:0] base_x, corr_x, left_w, right_w;
  logic signed [VW-1:0] left_sat, right_sat;
  logic [VW-1:0]        left_nxt, right_nxt;
  logic                 fin_nxt, halt_nxt;

  assign corr = {{(CW-QPW){qp[QPW-1]}}, qp}
              + {{(CW-QIW){qi[QIW-1]}}, qi}
              + {{(CW-QDW){qd[QDW-1]}}, qd};

  assign base_x  = {{(LW-VW){base_speed_r[VW-1]}}, base_speed_r};
  assign corr_x  = {corr[CW-1], corr};
  assign left_w  = base_x - corr_x;
  assign right_w = base_x + corr_x;

  always_comb begin
    if (left_w > LIM_HI)       left_sat = pidlf_pkg::DRIVE_MAX;
    else if (left_w < LIM_LO)  left_sat = pidlf_pkg::DRIVE_MIN;
    else                       left_sat = left_w[VW-1:0];
    if (right_w > LIM_HI)      right_sat = pidlf_pkg::DRIVE_MAX;
    else if (right_w < LIM_LO) right_sat = pidlf_pkg::DRIVE_MIN;
    else                       right_sat = right_w[VW-1:0];
  end

  always_comb begin
    left_nxt  = '0;
    right_nxt = '0;
    fin_nxt   = 1'b0;
    halt_nxt  = 1'b0;
    if (flags2_r.kill) begin
      // run over: all-zero result
    end else if (flags2_r.upside) begin
      halt_nxt = 1'b1;
    end else begin
      left_nxt  = left_sat;
      right_nxt = right_sat;
      fin_nxt   = flags2_r.done;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic [VW-1:0] left_r, right_r;
  logic          fin_r, halt_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      fin_r   <= fin_nxt;
      halt_r  <= halt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, halt_r, fin_r, right_r, left_r};

endmodule

>>> hdl/pidlf_term.sv
// ----------------------------------------------------------------------------
// pidlf_term - one Q8.8 gain term
// Registered signed product, then truncation toward zero to an integer.
// ----------------------------------------------------------------------------
module pidlf_term #(
  parameter int A_W = 13
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [A_W-1:0]                a,
  input  logic signed [pidlf_pkg::GAIN_W-1:0]  gain,
  output logic signed [A_W+pidlf_pkg::GAIN_W-9:0] q
);

  localparam int P_W = A_W + pidlf_pkg::GAIN_W;

  logic signed [P_W-1:0] prod_r;
  logic signed [P_W-1:0] prod_adj;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * gain;
    end
  end

  // bias negatives by 255 so the shift rounds toward zero
  assign prod_adj = prod_r + {{(P_W-8){1'b0}}, {8{prod_r[P_W-1]}}};
  assign q        = prod_adj[P_W-1:8];

endmodule

>>> hdl/pidlf_checker.sv
// ----------------------------------------------------------------------------
// pidlf_checker - port-level checks for pid_line_follower
// Drive range, halt/finish consistency, output hold and input availability.
// ----------------------------------------------------------------------------
`include "pid_line_follower_defines.svh"

module pidlf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pidlf_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic signed [pidlf_pkg::DRIVE_W-1:0] left_drive, right_drive;

  assign left_drive  = out_tdata[9:0];
  assign right_drive = out_tdata[19:10];

  `PIDLF_ASSERT_NOW(a_drive_range, out_tvalid, (left_drive <= pidlf_pkg::DRIVE_MAX) && (left_drive >= pidlf_pkg::DRIVE_MIN) && (right_drive <= pidlf_pkg::DRIVE_MAX) && (right_drive >= pidlf_pkg::DRIVE_MIN), "drive out of range")
  `PIDLF_ASSERT_NOW(a_halt_zero, out_tvalid && out_tdata[21], (left_drive == '0) && (right_drive == '0) && !out_tdata[20], "halted result with drive or finish")
  `PIDLF_ASSERT_NOW(a_bubble_ready, !out_tvalid, in_tready, "input blocked with empty output")
  `PIDLF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind pid_line_follower pidlf_checker u_pidlf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking testbench for pid_line_follower
// Streams sensor samples into the controller and checks every drive result
// against an in-bench prediction of the error, integral, derivative and
// saturation arithmetic. Runs a short directed pass, an integral windup
// sweep both ways, then random samples over random register settings,
// with random idling on both sides of the stream.
// ----------------------------------------------------------------------------
module tb;

  // package constants used here
  localparam int SENSOR_W       = pidlf_pkg::SENSOR_W;
  localparam int PROX_W         = pidlf_pkg::PROX_W;
  localparam int ACCEL_W        = pidlf_pkg::ACCEL_W;
  localparam int DRIVE_W        = pidlf_pkg::DRIVE_W;
  localparam int CFG_ADDR_W     = pidlf_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W     = pidlf_pkg::CFG_DATA_W;
  localparam int IN_DATA_W      = pidlf_pkg::IN_DATA_W;
  localparam int OUT_DATA_W     = pidlf_pkg::OUT_DATA_W;
  localparam int ACCUM_BITS_DEF = pidlf_pkg::ACCUM_BITS_DEF;
  localparam int DRIVE_LIMIT    = pidlf_pkg::DRIVE_LIMIT;
  localparam int FINISH_PROX    = int'(pidlf_pkg::FINISH_PROX);

  typedef pidlf_pkg::cfg_reg_t cfg_reg_t;

  // in_tdata / out_tdata field positions
  localparam int PROX_L_LSB   = 56;
  localparam int PROX_R_LSB   = 59;
  localparam int ACCEL_LSB    = 62;
  localparam int LEFT_LSB     = 0;
  localparam int RIGHT_LSB    = 10;
  localparam int FINISHED_BIT = 20;
  localparam int HALTED_BIT   = 21;

  localparam int PIPE_LAT       = 3;             // pipeline allowance within SETTLE
  localparam int SETTLE         = PIPE_LAT + 4;  // quiet edges before a reg write
  localparam int HOLD_CYCLES    = 64;            // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;          // edges with no transfer at all
  localparam int WINDUP_STEPS   = 30;            // steps per leg of the windup sweep
  localparam int RANDOM_SAMPLES = 26;            // samples per random setting
  localparam int MAX_REPORTS    = 30;            // quiet after this many lines

  typedef struct packed {
    bit                           start_req;
    bit [4:0][SENSOR_W-1:0]       sensor;
    bit [PROX_W-1:0]              prox_left;
    bit [PROX_W-1:0]              prox_right;
    bit signed [ACCEL_W-1:0]      accel_z;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                      finished;
    logic                      halted;
  } drive_t;

  // --------------------------------------------------------------------------
  // Drive scoreboard: own copy of the registers and the controller state,
  // one predicted drive per accepted sample, checked in order.
  // Class members start at zero, which matches the post-reset state.
  // --------------------------------------------------------------------------
  class drive_scoreboard;
    longint gain_p, gain_i, gain_d, base_speed;
    bit     direction_sel, dark_line;
    longint error_sum, prev_error;
    bit     run_over;
    drive_t pending_drives[$];
    int     mismatches, samples, checked, finishes, halts;

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        pidlf_pkg::CFG_GAIN_P:        gain_p = longint'($signed(v));
        pidlf_pkg::CFG_GAIN_I:        gain_i = longint'($signed(v));
        pidlf_pkg::CFG_GAIN_D:        gain_d = longint'($signed(v));
        pidlf_pkg::CFG_BASE_SPEED:    base_speed = longint'($signed(v[DRIVE_W-1:0]));
        pidlf_pkg::CFG_DIRECTION_SEL: direction_sel = v[0];
        pidlf_pkg::CFG_DARK_LINE:     dark_line = v[0];
        default: ;
      endcase
    endfunction

    // one accepted sample -> one expected drive
    function void predict_drive(logic [IN_DATA_W-1:0] d);
      longint s[5];
      longint err, deriv, corr, lft, rgt, sum_max;
      int     prox;
      int     i;
      drive_t r;
      sum_max = (longint'(1) <<< (ACCUM_BITS_DEF - 1)) - 1;
      samples++;
      r = '0;
      if (d[0]) begin
        error_sum = 0;
        prev_error = 0;
        run_over = 1'b0;
      end
      // once the run is over, everything reads zero and state is frozen
      if (!run_over) begin
        for (i = 0; i < 5; i++) s[i] = longint'(d[1 + SENSOR_W * i +: SENSOR_W]);
        prox = int'(d[PROX_L_LSB +: PROX_W]) + int'(d[PROX_R_LSB +: PROX_W]);
        if (!dark_line) err = s[3] - s[1];
        else if (direction_sel) err = s[0] + s[1] - s[2] - s[3];
        else err = s[1] + s[2] - s[3] - s[4];
        error_sum = clip(error_sum + err, -sum_max - 1, sum_max);
        deriv = err - prev_error;
        prev_error = err;
        // Q8.8 products, each truncated toward zero before the sum
        corr = err * gain_p / 256 + error_sum * gain_i / 256 + deriv * gain_d / 256;
        lft = clip(base_speed - corr, -DRIVE_LIMIT, DRIVE_LIMIT);
        rgt = clip(base_speed + corr, -DRIVE_LIMIT, DRIVE_LIMIT);
        if (d[ACCEL_LSB + ACCEL_W - 1]) begin
          // upside down: zero drives, no finish even at a full proximity count
          r.halted = 1'b1;
          run_over = 1'b1;
        end else begin
          r.left_drive = lft[DRIVE_W-1:0];
          r.right_drive = rgt[DRIVE_W-1:0];
          r.finished = (prox == FINISH_PROX);
          if (r.finished) run_over = 1'b1;
        end
      end
      pending_drives.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endtask

    task check_drive(logic [OUT_DATA_W-1:0] d);
      drive_t want;
      checked++;
      if (pending_drives.size() == 0) begin
        report_mismatch($sformatf("drive result %0d with nothing predicted: %h", checked, d));
        return;
      end
      want = pending_drives.pop_front();
      if (want.finished) finishes++;
      if (want.halted) halts++;
      if (d[LEFT_LSB +: DRIVE_W] !== want.left_drive)
        report_mismatch($sformatf("result %0d left_drive %0d, predicted %0d", checked,
                                  $signed(d[LEFT_LSB +: DRIVE_W]), want.left_drive));
      if (d[RIGHT_LSB +: DRIVE_W] !== want.right_drive)
        report_mismatch($sformatf("result %0d right_drive %0d, predicted %0d", checked,
                                  $signed(d[RIGHT_LSB +: DRIVE_W]), want.right_drive));
      if (d[FINISHED_BIT] !== want.finished)
        report_mismatch($sformatf("result %0d finished %b, predicted %b", checked,
                                  d[FINISHED_BIT], want.finished));
      if (d[HALTED_BIT] !== want.halted)
        report_mismatch($sformatf("result %0d halted %b, predicted %b", checked,
                                  d[HALTED_BIT], want.halted));
    endtask

    task check_leftovers();
      if (pending_drives.size() != 0)
        report_mismatch($sformatf("%0d predicted drives never came out",
                                  pending_drives.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // start_req, sensor_0..4, prox_l/r, accel_z
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // left_drive, right_drive, finished, halted

  drive_scoreboard sb;
  bit              idle_in, idle_out;   // random gaps allowed on each side
  bit              hold_request;        // ask the receiver for one long hold-off
  int              settings_applied;
  int              quiet_cycles;

  pid_line_follower u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor and watchdog. Everything is driven with NBAs at the edge, so the
  // values read here are the ones that were stable before the edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.predict_drive(in_tdata);
      if (out_tvalid && out_tready) sb.check_drive(out_tdata);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request so the
  // pipeline fills and in_tready drops while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_out && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  function automatic logic [IN_DATA_W-1:0] pack_sample(sample_t s);
    logic [IN_DATA_W-1:0] d;
    int                   i;
    d = '0;
    d[0] = s.start_req;
    for (i = 0; i < 5; i++) d[1 + SENSOR_W * i +: SENSOR_W] = s.sensor[i];
    d[PROX_L_LSB +: PROX_W] = s.prox_left;
    d[PROX_R_LSB +: PROX_W] = s.prox_right;
    d[ACCEL_LSB +: ACCEL_W] = s.accel_z;
    return d;
  endfunction

  function automatic sample_t mk(int st, int s0, int s1, int s2, int s3, int s4,
                                 int pl, int pr, int az);
    sample_t s;
    s.start_req = st[0];
    s.sensor[0] = s0[SENSOR_W-1:0];
    s.sensor[1] = s1[SENSOR_W-1:0];
    s.sensor[2] = s2[SENSOR_W-1:0];
    s.sensor[3] = s3[SENSOR_W-1:0];
    s.sensor[4] = s4[SENSOR_W-1:0];
    s.prox_left = pl[PROX_W-1:0];
    s.prox_right = pr[PROX_W-1:0];
    s.accel_z = az[ACCEL_W-1:0];
    return s;
  endfunction

  // full-range sensors; proximity mostly below the finish count; rare flips
  function automatic sample_t random_sample();
    sample_t s;
    int      i;
    s.start_req = ($urandom_range(0, 7) == 0);
    for (i = 0; i < 5; i++) s.sensor[i] = SENSOR_W'($urandom_range(0, 2047));
    if ($urandom_range(0, 5) == 0) begin
      s.prox_left = PROX_W'($urandom_range(0, 7));
      s.prox_right = PROX_W'($urandom_range(0, 7));
    end else begin
      s.prox_left = PROX_W'($urandom_range(0, 5));
      s.prox_right = PROX_W'($urandom_range(0, 5));
    end
    s.accel_z = ($urandom_range(0, 24) == 0) ? 16'($urandom_range(32768, 65535))
                                             : 16'($urandom_range(0, 32767));
    return s;
  endfunction

  // offer one sample, hold it until the transfer, then maybe idle a while
  task automatic send_sample(sample_t s);
    in_tdata <= pack_sample(s);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (idle_in && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // stop sending and let every predicted drive come out, then a few more
  // edges so the pipeline is surely empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // all six registers, back to back, only on an idle block
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] gp, gi, gd, base,
                                input bit dir, dark);
    cfg_reg_t              idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    int                    k;
    idx = '{pidlf_pkg::CFG_GAIN_P, pidlf_pkg::CFG_GAIN_I, pidlf_pkg::CFG_GAIN_D,
            pidlf_pkg::CFG_BASE_SPEED, pidlf_pkg::CFG_DIRECTION_SEL,
            pidlf_pkg::CFG_DARK_LINE};
    val = '{gp, gi, gd, base, 16'(dir), 16'(dark)};
    wait_idle();
    cfg_wr_en <= 1'b1;
    for (k = 0; k < 6; k++) begin
      cfg_addr <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_wr_en <= 1'b0;
    settings_applied++;
  endtask

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] g [3];
    int                    k;
    for (k = 0; k < 3; k++) begin
      case ($urandom_range(0, 2))
        0: g[k] = 16'($urandom);
        1: g[k] = 16'(int'($urandom_range(0, 1024)) - 512);
        default: g[k] = 16'(int'($urandom_range(0, 64)) - 32);
      endcase
    end
    apply_settings(g[0], g[1], g[2], 16'(int'($urandom_range(0, 800)) - 400),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // --------------------------------------------------------------------------
  // Directed: reset settings, all three error forms, gain and base extremes,
  // finish, upside down (also on a full proximity count), frozen run, restart
  // --------------------------------------------------------------------------
  task automatic run_directed();
    idle_in = 1'b0;
    idle_out = 1'b0;
    // registers still at reset: zero gains, two-sensor difference
    send_sample(mk(1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(mk(0, 2047, 2047, 2047, 2047, 2047, 7, 7, 32767));
    // four-sensor error, left side
    apply_settings(16'h0100, 16'h0004, 16'h0080, 16'd200, 1'b1, 1'b1);
    send_sample(mk(1, 2047, 2047, 0, 0, 0, 0, 0, 32767));    // largest positive error
    send_sample(mk(0, 0, 0, 2047, 2047, 2047, 3, 4, 1));     // largest swing
    send_sample(mk(0, 2000, 2000, 2000, 2000, 2000, 6, 5, 0)); // zero error
    send_sample(mk(0, 1500, 200, 900, 40, 7, 6, 6, 0));      // finish on 6+6
    send_sample(mk(0, 100, 200, 300, 400, 500, 1, 2, 500));  // run over: zeros
    send_sample(mk(0, 2047, 0, 0, 0, 0, 6, 6, -5));          // still over
    send_sample(mk(1, 700, 800, 100, 50, 0, 6, 6, -32768));  // upside down beats finish
    send_sample(mk(0, 10, 20, 30, 40, 50, 0, 0, 1000));      // halted run stays over
    send_sample(mk(1, 1, 2, 3, 4, 5, 5, 7, 32767));          // finish on 5+7
    send_sample(mk(1, 0, 0, 0, 0, 0, 7, 5, -1));             // upside down on 7+5
    // four-sensor error, right side; gains at their extremes, slowest base
    apply_settings(16'h7FFF, 16'h8000, 16'h7FFF, -16'sd400, 1'b0, 1'b1);
    send_sample(mk(1, 0, 2047, 2047, 0, 0, 0, 0, 20));
    send_sample(mk(0, 0, 0, 0, 2047, 2047, 7, 0, 20));
    send_sample(mk(0, 5, 3, 9, 1, 12, 0, 7, 20));
    // two-sensor difference, opposite gain extremes, fastest base
    apply_settings(16'h8000, 16'h7FFF, 16'h8000, 16'd400, 1'b1, 1'b0);
    send_sample(mk(1, 2047, 0, 2047, 2047, 2047, 1, 1, 10));
    send_sample(mk(0, 0, 2047, 0, 0, 0, 1, 1, 10));
    send_sample(mk(0, 300, 1000, 300, 1003, 300, 2, 2, 10));
    // small errors with gain -1.0 so the drives stay off the rails
    apply_settings(16'hFF00, 16'h0000, 16'h0100, 16'd0, 1'b0, 1'b0);
    send_sample(mk(1, 0, 500, 0, 520, 0, 0, 0, 10));
    send_sample(mk(0, 0, 530, 0, 500, 0, 0, 0, 10));
  endtask

  // --------------------------------------------------------------------------
  // Integral windup: full error one way, twice as long the other way, then
  // back. The tiny integral gain makes the drives a slow ramp of the running
  // sum, so a wrong sum shows up as a shift in where the drives cross.
  // --------------------------------------------------------------------------
  task automatic run_windup();
    sample_t climb, dive;
    int      k;
    climb = mk(0, 2047, 2047, 0, 0, 0, 0, 0, 100);
    dive = mk(0, 0, 0, 2047, 2047, 0, 0, 0, 100);
    apply_settings(16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b1);
    idle_in = 1'b1;
    idle_out = 1'b1;
    climb.start_req = 1'b1;
    send_sample(climb);
    climb.start_req = 1'b0;
    for (k = 0; k < WINDUP_STEPS; k++) send_sample(climb);
    for (k = 0; k < 2 * WINDUP_STEPS; k++) send_sample(dive);
    for (k = 0; k < WINDUP_STEPS; k++) send_sample(climb);
  endtask

  // --------------------------------------------------------------------------
  // Random: ten register settings, a batch of samples each. Idling rotates
  // through none / sender only / receiver only / both; one setting gets the
  // long receiver hold-off while the sender streams.
  // --------------------------------------------------------------------------
  task automatic run_random();
    int k, n;
    for (k = 0; k < 10; k++) begin
      random_settings();
      idle_in = (k % 4 == 1) || (k % 4 == 3);
      idle_out = (k % 4 == 2) || (k % 4 == 3);
      if (k == 4) hold_request = 1'b1;
      for (n = 0; n < RANDOM_SAMPLES; n++) send_sample(random_sample());
    end
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_windup();
    run_random();
    wait_idle();
    sb.check_leftovers();

    $display("Ran %0d samples, %0d drive results checked, over %0d register settings",
             sb.samples, sb.checked, settings_applied);
    $display("Saw %0d finishes and %0d upside-down halts; integral swept both ways",
             sb.finishes, sb.halts);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> pid_line_follower.f
+incdir+hdl
hdl/pidlf_pkg.sv
hdl/pidlf_term.sv
hdl/pid_line_follower.sv
hdl/pidlf_checker.sv
tb/tb.sv
